// ===== hdl/fixed_unit_free_index_ring_defines.svh =====
// assertion macros for the free index ring
`ifndef FIXED_UNIT_FREE_INDEX_RING_DEFINES_SVH
`define FIXED_UNIT_FREE_INDEX_RING_DEFINES_SVH

// same-cycle implication
`define FUIR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FUIR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fuir_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fuir_pkg;

   localparam int MAX_UNITS_DEF = 1024;

   localparam int INDEX_W      = 10;
   localparam int OFFSET_W     = 26;
   localparam int OP_W         = 2;
   localparam int UNIT_COUNT_W = 11;
   localparam int UNIT_SIZE_W  = 16;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [UNIT_COUNT_W-1:0] UNIT_COUNT_RST = 11'd1024;
   localparam logic [UNIT_SIZE_W-1:0]  UNIT_SIZE_RST  = 16'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT_SIZE  = 2'd1;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_RANGE    = 3'd3,
      ST_NOT_USED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [INDEX_W-1:0] unit_num;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  granted_index;
      logic [OFFSET_W-1:0] byte_offset;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/fuir_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fuir_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/fuir_csr.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fuir_csr #(
   parameter int MAX_UNITS = fuir_pkg::MAX_UNITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [fuir_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fuir_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic      [$clog2(MAX_UNITS):0]         eff_count,
   output logic      [fuir_pkg::UNIT_SIZE_W-1:0]   unit_size
);

   import fuir_pkg::*;

   localparam int CW = $clog2(MAX_UNITS) + 1;
   localparam int WW = (CW > UNIT_COUNT_W) ? CW : UNIT_COUNT_W;

   logic [UNIT_COUNT_W-1:0] unit_count_ff, unit_count_in;
   logic [UNIT_SIZE_W-1:0]  unit_size_ff, unit_size_in;

   assign csr_ready = 1'b1;

   always_comb begin
      unit_count_in = unit_count_ff;
      unit_size_in  = unit_size_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_UNIT_COUNT: unit_count_in = csr_wdata[UNIT_COUNT_W-1:0];
            CSR_UNIT_SIZE:  unit_size_in  = csr_wdata[UNIT_SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_count_ff <= UNIT_COUNT_RST;
         unit_size_ff  <= UNIT_SIZE_RST;
      end else begin
         unit_count_ff <= unit_count_in;
         unit_size_ff  <= unit_size_in;
      end
   end

   // zero acts as one, anything above the pool size acts as the pool size
   always_comb begin
      priority if (unit_count_ff == '0) begin
         eff_count = CW'(1);
      end else if (WW'(unit_count_ff) > WW'(MAX_UNITS)) begin
         eff_count = CW'(MAX_UNITS);
      end else begin
         eff_count = CW'(unit_count_ff);
      end
   end

   assign unit_size = unit_size_ff;

endmodule

`default_nettype wire

// ===== hdl/fuir_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fuir_engine #(
   parameter int MAX_UNITS = fuir_pkg::MAX_UNITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [$clog2(MAX_UNITS):0]        eff_count,
   input  wire logic [fuir_pkg::UNIT_SIZE_W-1:0]  unit_size,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire fuir_pkg::req_type                 req_data,
   input  wire logic                              rsp_free,
   output logic                                   rsp_load,
   output fuir_pkg::rsp_type                      rsp_load_data
);

   import fuir_pkg::*;

   localparam int IW = $clog2(MAX_UNITS);
   localparam int CW = IW + 1;
   localparam int WW = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int OW = (IW > INDEX_W) ? IW : INDEX_W;
   localparam int PW = OW + UNIT_SIZE_W;
   localparam logic [IW-1:0] LAST_ENTRY = IW'(MAX_UNITS - 1);

   state_type state_ff, state_in;

   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      used_ff, used_in;
   logic [IW-1:0]      clr_ff, clr_in;
   logic [OP_W-1:0]    op_ff, op_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;

   logic          accept, clearing, executing, fire;
   logic          alloc_ok, release_ok;
   status_type    status;
   logic [INDEX_W-1:0] granted;
   logic [OW-1:0] oper;
   logic [PW-1:0] product;

   logic          ring_we, flag_we, flag_wd;
   logic [IW-1:0] ring_wa, ring_wd, flag_wa;
   logic [IW-1:0] ring_rd;
   logic          flag_rd;

   function automatic logic [IW-1:0] advance(input logic [IW-1:0] pos,
                                             input logic [CW-1:0] count);
      logic [CW-1:0] nxt;
      nxt = CW'(pos) + CW'(1);
      advance = (nxt >= count) ? '0 : nxt[IW-1:0];
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: if (clr_ff == LAST_ENTRY) state_in = S_IDLE;
         S_IDLE:  if (req_valid) state_in = S_EXEC;
         S_EXEC:  if (rsp_free) state_in = S_IDLE;
         default: state_in = S_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      clearing  = 1'b0;
      executing = 1'b0;
      unique case (state_ff)
         S_CLEAR: clearing  = 1'b1;
         S_IDLE:  req_ready = 1'b1;
         S_EXEC:  executing = 1'b1;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;
   assign fire   = executing && rsp_free;

   // decision on the read data
   always_comb begin
      status     = ST_OK;
      granted    = '0;
      oper       = '0;
      alloc_ok   = 1'b0;
      release_ok = 1'b0;
      priority if (op_ff == OP_ALLOC) begin
         if (used_ff >= eff_count) begin
            status = ST_FULL;
         end else begin
            alloc_ok = 1'b1;
            granted  = INDEX_W'(ring_rd);
            oper     = OW'(ring_rd);
         end
      end else if (op_ff == OP_RELEASE) begin
         granted = idx_ff;
         if (WW'(idx_ff) >= WW'(eff_count)) begin
            status = ST_RANGE;
         end else if (used_ff == '0) begin
            status = ST_EMPTY;
         end else begin
            release_ok = 1'b1;
            oper       = OW'(idx_ff);
         end
      end else begin
         granted = idx_ff;
         if (WW'(idx_ff) >= WW'(eff_count)) begin
            status = ST_RANGE;
         end else if (!flag_rd) begin
            status = ST_NOT_USED;
         end else begin
            oper = OW'(idx_ff);
         end
      end
   end

   assign product = PW'(oper) * PW'(unit_size);

   assign rsp_load                    = fire;
   assign rsp_load_data.status        = status;
   assign rsp_load_data.granted_index = granted;
   assign rsp_load_data.byte_offset   = product[OFFSET_W-1:0];

   // memory write ports, clearing pass loads identity indices and free flags
   always_comb begin
      ring_we = clearing || (fire && release_ok);
      ring_wa = clearing ? clr_ff : tail_ff;
      ring_wd = clearing ? clr_ff : IW'(idx_ff);
      flag_we = clearing || (fire && (alloc_ok || release_ok));
      flag_wa = clearing ? clr_ff : (alloc_ok ? ring_rd : IW'(idx_ff));
      flag_wd = !clearing && alloc_ok;
   end

   fuir_ram #(
      .WIDTH (IW),
      .DEPTH (MAX_UNITS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_wa),
      .wr_data (ring_wd),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (ring_rd)
   );

   fuir_ram #(
      .WIDTH (1),
      .DEPTH (MAX_UNITS)
   ) u_flags (
      .clock   (clock),
      .wr_en   (flag_we),
      .wr_addr (flag_wa),
      .wr_data (flag_wd),
      .rd_en   (accept),
      .rd_addr (IW'(req_data.unit_num)),
      .rd_data (flag_rd)
   );

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      used_in = used_ff;
      clr_in  = clearing ? clr_ff + IW'(1) : clr_ff;
      op_in   = accept ? req_data.operation : op_ff;
      idx_in  = accept ? req_data.unit_num : idx_ff;
      if (fire && alloc_ok) begin
         head_in = advance(head_ff, eff_count);
         used_in = used_ff + CW'(1);
      end
      if (fire && release_ok) begin
         tail_in = advance(tail_ff, eff_count);
         used_in = used_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         head_ff  <= '0;
         tail_ff  <= '0;
         used_ff  <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         used_ff  <= used_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      idx_ff <= idx_in;
   end

endmodule

`default_nettype wire

// ===== hdl/fixed_unit_free_index_ring.sv =====
//  channel | ports                               | direction | moves
//  --------+-------------------------------------+-----------+---------------------------
//  req     | req_valid req_ready req_data        | in        | operation, unit index
//  rsp     | rsp_valid rsp_ready rsp_data        | out       | status, index, byte offset
//  csr     | csr_valid csr_ready csr_index/wdata | in        | unit count, unit size
//
//  each transaction is accepted together with its memory read, then decided and written back
//  the ring and flag memories each have one read and one write port, with registered read data
//  after reset a clearing pass over all MAX_UNITS entries loads the ring, req_ready stays low
//  csr writes are taken in every cycle, also during the clearing pass
//  a result waits in the output register; the next transaction is accepted meanwhile
//  and holds in its decide step until the output register frees
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_unit_free_index_ring_defines.svh"

module fixed_unit_free_index_ring #(
   parameter int MAX_UNITS = fuir_pkg::MAX_UNITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire fuir_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output fuir_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [fuir_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [fuir_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import fuir_pkg::*;

   logic [$clog2(MAX_UNITS):0] eff_count;
   logic [UNIT_SIZE_W-1:0]     unit_size;

   logic    rsp_free, rsp_load;
   rsp_type rsp_load_data;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   fuir_csr #(
      .MAX_UNITS (MAX_UNITS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .eff_count (eff_count),
      .unit_size (unit_size)
   );

   fuir_engine #(
      .MAX_UNITS (MAX_UNITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .eff_count     (eff_count),
      .unit_size     (unit_size),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_free      (rsp_free),
      .rsp_load      (rsp_load),
      .rsp_load_data (rsp_load_data)
   );

   // output register
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rsp_load_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FUIR_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready, "result overwrites a pending result")
   `FUIR_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "transaction accepted while one is in flight")
   `FUIR_ASSERT_NOW(a_fail_offset, clock, reset, rsp_load && (rsp_load_data.status != ST_OK), rsp_load_data.byte_offset == '0, "failed transaction carries an offset")

endmodule

`default_nettype wire
